@@ src/wfg_pkg.sv @@
// ============================================================================
// wfg_pkg: shared types and constants for the wait-for graph cycle detector
// Holds the transaction payload structs and the fixed sizes of the wait-for
// table that follow from the field widths.
// ============================================================================
package wfg_pkg;

  // Rows and columns of the wait-for table, fixed by the field widths.
  localparam int ADJ_ROWS = 8;
  localparam int ROW_W = 8;
  localparam int PROC_W = 3;

  // Default number of processes searched.
  localparam int DEFAULT_NUM_PROCS = 8;

  // Input transaction modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DETECT = 1'b1;

  typedef struct packed {
    logic mode;
    logic [PROC_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic found;
    logic [PROC_W-1:0] process;
    logic last;
  } out_item_t;

endpackage

@@ src/wfg_dfs_engine.sv @@
// ============================================================================
// wfg_dfs_engine: wait-for table and depth-first search sequencer
// Stores the wait-for rows and walks the graph one neighbor check per cycle.
// On the first back edge it replays the cycle from the search stack.
// ============================================================================
module wfg_dfs_engine
  import wfg_pkg::*;
#(
  parameter int NUM_PROCS = DEFAULT_NUM_PROCS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  // Node index width, and a width that also holds NUM_PROCS itself.
  localparam int NW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int JW = $clog2(NUM_PROCS + 1);
  localparam int NXW = (NW > PROC_W) ? NW : PROC_W;
  localparam int JXW = (JW > PROC_W) ? JW : PROC_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROOT = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_NONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [ROW_W-1:0] adj_r [ADJ_ROWS];
  logic [NUM_PROCS-1:0] visited_r, visited_nxt;
  logic [NUM_PROCS-1:0] onpath_r, onpath_nxt;
  logic [JW-1:0] root_r, root_nxt;
  logic [JW-1:0] depth_r, depth_nxt;
  logic [NW-1:0] cur_u_r, cur_u_nxt;
  logic [JW-1:0] cur_j_r, cur_j_nxt;
  logic [NW-1:0] target_r, target_nxt;
  logic [NW-1:0] idx_r, idx_nxt;

  // Search stack: node of each frame and its next neighbor to try.
  logic [NW-1:0] node_mem [NUM_PROCS];
  logic [JW-1:0] next_mem [NUM_PROCS];

  logic node_we, next_we;
  logic [NW-1:0] node_waddr, next_waddr;
  logic [NW-1:0] node_wdata;
  logic [JW-1:0] next_wdata;

  logic [NW-1:0] rd_addr;
  logic [NW-1:0] rd_node;
  logic [JW-1:0] rd_next;

  logic [JW-1:0] depth_m1, depth_m2;
  logic [NXW-1:0] u_ext, rd_node_ext;
  logic [JXW-1:0] j_ext;
  logic [NW-1:0] j_idx;
  logic j_done, edge_hit, is_last;
  logic [ROW_W-1:0] cur_row;

  assign depth_m1 = depth_r - JW'(1);
  assign depth_m2 = depth_r - JW'(2);
  assign j_idx = cur_j_r[NW-1:0];
  assign u_ext = NXW'(cur_u_r);
  assign j_ext = JXW'(cur_j_r);
  assign j_done = (cur_j_r == JW'(NUM_PROCS));

  // Row of the current node; nodes beyond the table have no edges.
  assign cur_row = (int'(u_ext) < ADJ_ROWS) ? adj_r[u_ext[PROC_W-1:0]] : '0;
  assign edge_hit = !j_done && (int'(j_ext) < ROW_W) && cur_row[j_ext[PROC_W-1:0]];

  // One stack read port, shared by the pop path and the cycle replay.
  assign rd_addr = (state_r == S_SCAN) ? depth_m2[NW-1:0] : idx_r;
  assign rd_node = node_mem[rd_addr];
  assign rd_next = next_mem[rd_addr];
  assign rd_node_ext = NXW'(rd_node);
  assign is_last = (idx_r == depth_m1[NW-1:0]);

  assign item_ready = (state_r == S_IDLE);

  // Result presented to the output stage.
  always_comb begin
    res_valid = 1'b0;
    res = '0;
    case (state_r)
      S_EMIT: begin
        res_valid = 1'b1;
        res.found = 1'b1;
        res.process = rd_node_ext[PROC_W-1:0];
        res.last = is_last;
      end
      S_NONE: begin
        res_valid = 1'b1;
        res.last = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Search sequencer.
  always_comb begin
    state_nxt = state_r;
    visited_nxt = visited_r;
    onpath_nxt = onpath_r;
    root_nxt = root_r;
    depth_nxt = depth_r;
    cur_u_nxt = cur_u_r;
    cur_j_nxt = cur_j_r;
    target_nxt = target_r;
    idx_nxt = idx_r;
    node_we = 1'b0;
    node_waddr = '0;
    node_wdata = '0;
    next_we = 1'b0;
    next_waddr = '0;
    next_wdata = '0;
    case (state_r)
      S_IDLE: begin
        if (item_valid && item.mode == MODE_DETECT) begin
          visited_nxt = '0;
          onpath_nxt = '0;
          depth_nxt = '0;
          root_nxt = '0;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_r == JW'(NUM_PROCS)) begin
          state_nxt = S_NONE;
        end else if (visited_r[root_r[NW-1:0]]) begin
          root_nxt = root_r + JW'(1);
        end else begin
          // Push the root as the only frame.
          node_we = 1'b1;
          node_waddr = '0;
          node_wdata = root_r[NW-1:0];
          visited_nxt[root_r[NW-1:0]] = 1'b1;
          onpath_nxt[root_r[NW-1:0]] = 1'b1;
          depth_nxt = JW'(1);
          cur_u_nxt = root_r[NW-1:0];
          cur_j_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (j_done) begin
          // All neighbors tried: pop this node.
          onpath_nxt[cur_u_r] = 1'b0;
          depth_nxt = depth_m1;
          if (depth_r == JW'(1)) begin
            root_nxt = root_r + JW'(1);
            state_nxt = S_ROOT;
          end else begin
            cur_u_nxt = rd_node;
            cur_j_nxt = rd_next;
          end
        end else if (edge_hit && !visited_r[j_idx]) begin
          // Tree edge: save where the parent resumes and descend.
          next_we = 1'b1;
          next_waddr = depth_m1[NW-1:0];
          next_wdata = cur_j_r + JW'(1);
          node_we = 1'b1;
          node_waddr = depth_r[NW-1:0];
          node_wdata = j_idx;
          visited_nxt[j_idx] = 1'b1;
          onpath_nxt[j_idx] = 1'b1;
          depth_nxt = depth_r + JW'(1);
          cur_u_nxt = j_idx;
          cur_j_nxt = '0;
        end else if (edge_hit && onpath_r[j_idx]) begin
          // Back edge: a cycle closes at this neighbor.
          target_nxt = j_idx;
          idx_nxt = '0;
          state_nxt = S_FIND;
        end else begin
          cur_j_nxt = cur_j_r + JW'(1);
        end
      end
      S_FIND: begin
        if (rd_node == target_r) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + NW'(1);
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + NW'(1);
          end
        end
      end
      S_NONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and mark registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      visited_r <= '0;
      onpath_r <= '0;
      root_r <= '0;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      visited_r <= visited_nxt;
      onpath_r <= onpath_nxt;
      root_r <= root_nxt;
      depth_r <= depth_nxt;
    end
  end

  // Datapath registers of the current frame.
  always_ff @(posedge clk) begin
    cur_u_r <= cur_u_nxt;
    cur_j_r <= cur_j_nxt;
    target_r <= target_nxt;
    idx_r <= idx_nxt;
  end

  // Wait-for table: one row written per load transaction whose row index is below NUM_PROCS.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ADJ_ROWS; i++) begin
        adj_r[i] <= '0;
      end
    end else if (item_valid && item_ready && item.mode == MODE_LOAD &&
                 int'(item.row_index) < NUM_PROCS) begin
      adj_r[item.row_index] <= item.row_bits;
    end
  end

  // Search stack writes.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

endmodule

@@ src/wait_for_graph_cycle_detector.sv @@
// ============================================================================
// wait_for_graph_cycle_detector: deadlock detector over a wait-for graph
// Loads wait-for rows and searches the graph depth first for a cycle.
// ============================================================================
// Usage: the input channel carries one transaction per command. A load
// transaction (mode 0) writes the wait-for row of one process and gives no
// result; it is taken while the block is idle. A detect transaction (mode 1)
// clears the search marks and runs a depth-first search from process 0
// upward, trying neighbors in ascending order. The search checks one
// neighbor per cycle in a single sequencer; on a back edge it then locates
// the cycle start on the search stack.
// On a cycle, one result per member comes out, from the back-edge target to
// the detecting process, the final one flagged by last. Without a cycle one
// result with found low and last high comes out. The input is not ready
// while a detection runs. Results pass through an output register, so the
// next command is accepted while the final result still waits; a stalled
// receiver holds the search at its current result. Reset clears the table
// to no edges and returns the block to idle.
module wait_for_graph_cycle_detector
  import wfg_pkg::*;
#(
  parameter int NUM_PROCS = DEFAULT_NUM_PROCS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic res_valid, res_ready;
  out_item_t res;
  logic out_valid_r;
  out_item_t out_data_r;

  wfg_dfs_engine #(
    .NUM_PROCS(NUM_PROCS)
  ) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .item_valid(in_valid),
    .item_ready(in_ready),
    .item(in_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  // Output register: refilled whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

@@ tb/sv/wfg_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfg_result_checker: predicts and checks deadlock detector results
// Watches both channels of the wait-for graph cycle detector. Every accepted
// load updates a private copy of the wait-for table. Every accepted detect
// runs a depth-first search on that copy and queues the expected cycle
// members. Each accepted result is compared, field by field, with the oldest
// queued expectation.
// ----------------------------------------------------------------------------
module wfg_result_checker
  import wfg_pkg::*;
#(
  parameter int N_PROCS = DEFAULT_NUM_PROCS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        outstanding
);

  // Private copy of the wait-for table and the queue of expected results.
  logic [ROW_W-1:0] wait_rows [ADJ_ROWS];
  out_item_t        cycle_q[$];
  int               err_cnt;

  // Depth-first search over the table copy, queueing the expected results.
  function automatic void predict_cycle();
    logic [ADJ_ROWS-1:0] seen;
    logic [ADJ_ROWS-1:0] on_path;
    int                  stk_node [ADJ_ROWS];
    int                  stk_next [ADJ_ROWS];
    int                  depth;
    int                  u;
    int                  j;
    int                  p;
    logic [PROC_W-1:0]   member;
    out_item_t           res;
    seen = '0;
    on_path = '0;
    depth = 0;
    for (int root = 0; root < N_PROCS; root++) begin
      if (!seen[root]) begin
        stk_node[0] = root;
        stk_next[0] = 0;
        depth = 1;
        seen[root] = 1'b1;
        on_path[root] = 1'b1;
        while (depth > 0) begin
          u = stk_node[depth-1];
          j = stk_next[depth-1];
          while (j < N_PROCS && !(j < ROW_W && wait_rows[u][j])) j++;
          if (j >= N_PROCS) begin
            // All neighbors tried: the node leaves the search path.
            on_path[u] = 1'b0;
            depth--;
          end else begin
            stk_next[depth-1] = j + 1;
            if (!seen[j]) begin
              stk_node[depth] = j;
              stk_next[depth] = 0;
              depth++;
              seen[j] = 1'b1;
              on_path[j] = 1'b1;
            end else if (on_path[j]) begin
              // Back edge: the cycle runs from j along the path to u.
              p = 0;
              while (stk_node[p] != j) p++;
              for (int k = p; k < depth; k++) begin
                member = PROC_W'(stk_node[k]);
                res = {1'b1, member, (k == depth - 1)};
                cycle_q.push_back(res);
              end
              return;
            end
          end
        end
      end
    end
    // No cycle anywhere in the graph.
    res = {1'b0, {PROC_W{1'b0}}, 1'b1};
    cycle_q.push_back(res);
  endfunction

  // Compare a result with the oldest expectation, field by field.
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (cycle_q.size() == 0) begin
      $error("unexpected result: found=%0d process=%0d last=%0d",
             got[4], got[3:1], got[0]);
      err_cnt++;
    end else begin
      want = cycle_q.pop_front();
      if (got[4] !== want[4]) begin
        $error("found: expected %0d, actual %0d", want[4], got[4]);
        err_cnt++;
      end
      if (got[3:1] !== want[3:1]) begin
        $error("process: expected %0d, actual %0d", want[3:1], got[3:1]);
        err_cnt++;
      end
      if (got[0] !== want[0]) begin
        $error("last: expected %0d, actual %0d", want[0], got[0]);
        err_cnt++;
      end
    end
  endtask

  initial begin
    err_cnt = 0;
    fail_count = 0;
    outstanding = 0;
  end

  // Track the table on loads, predict on detects, check every result.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ADJ_ROWS; r++) wait_rows[r] = '0;
      cycle_q.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_LOAD) begin
          if (in_data.row_index < N_PROCS) wait_rows[in_data.row_index] = in_data.row_bits;
        end else begin
          predict_cycle();
        end
      end
    end
    fail_count <= err_cnt;
    outstanding <= cycle_q.size();
  end

endmodule

@@ tb/sv/wait_for_graph_cycle_detector_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wait_for_graph_cycle_detector_tb: top of the deadlock detector testbench
// Drives load and detect transactions into the detector: a directed part
// with self waits, a full-length cycle, cross edges and an empty graph, then
// random graph builds followed by detects. Sender gaps and receiver stalls
// vary by phase, and one long receiver hold fills the block. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module wait_for_graph_cycle_detector_tb;
  import wfg_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int          fail_count;
  int          outstanding;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_cnt = 0;
  int          cmd_count = 0;
  int          cycle_count = 0;

  wait_for_graph_cycle_detector uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  wfg_result_checker chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one transaction, with a random gap before it, and wait for it.
  task automatic send_cmd(input logic m, input logic [PROC_W-1:0] idx,
                          input logic [ROW_W-1:0] bits);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data <= {m, idx, bits};
    do @(posedge clk); while (!in_ready);
    cmd_count++;
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Random wait-for row, mostly sparse so that long chains appear.
  function automatic logic [ROW_W-1:0] pick_row();
    logic [ROW_W-1:0] bits;
    case ($urandom_range(5))
      0: bits = '0;
      1: bits = 8'h01 << $urandom_range(7);
      2: bits = (8'h01 << $urandom_range(7)) | (8'h01 << $urandom_range(7));
      3: bits = ROW_W'($urandom & $urandom);
      4: bits = 8'hFF;
      default: bits = ROW_W'($urandom);
    endcase
    return bits;
  endfunction

  // One random sequence: acyclic build with an optional back edge,
  // a few scattered row writes, or a lone transaction as noise.
  task automatic random_sequence();
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] bits;
    int               a;
    int               b;
    int               n;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        a = $urandom_range(1, 7);
        b = $urandom_range(0, a);
        n = $urandom_range(1);
        for (int r = 0; r < ADJ_ROWS; r++) begin
          mask = 8'hFF << (r + 1);
          bits = pick_row() & mask;
          if (n == 1 && r == a) bits[b] = 1'b1;
          send_cmd(MODE_LOAD, PROC_W'(r), bits);
        end
        send_cmd(MODE_DETECT, PROC_W'($urandom), ROW_W'($urandom));
      end
      5, 6, 7, 8: begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) send_cmd(MODE_LOAD, PROC_W'($urandom), pick_row());
        send_cmd(MODE_DETECT, PROC_W'($urandom), ROW_W'($urandom));
      end
      default: begin
        send_cmd(1'($urandom), PROC_W'($urandom), ROW_W'($urandom));
      end
    endcase
  endtask

  initial begin
    int phase_end;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty graph, self waits at both ends, a full-length cycle,
    // a shorter cycle through a full row, cross edges into old branches.
    send_cmd(MODE_DETECT, 3'd0, 8'h00);
    send_cmd(MODE_LOAD, 3'd0, 8'h01);
    send_cmd(MODE_DETECT, 3'd7, 8'hFF);
    send_cmd(MODE_LOAD, 3'd0, 8'h00);
    send_cmd(MODE_LOAD, 3'd7, 8'h80);
    send_cmd(MODE_DETECT, 3'd0, 8'h00);
    for (int r = 0; r < ADJ_ROWS; r++) begin
      send_cmd(MODE_LOAD, PROC_W'(r), 8'h01 << ((r + 1) % 8));
    end
    send_cmd(MODE_DETECT, 3'd5, 8'hA5);
    send_cmd(MODE_LOAD, 3'd3, 8'hFF);
    send_cmd(MODE_DETECT, 3'd0, 8'h00);
    send_cmd(MODE_LOAD, 3'd0, 8'h00);
    send_cmd(MODE_DETECT, 3'd0, 8'h00);
    send_cmd(MODE_LOAD, 3'd1, 8'h00);
    send_cmd(MODE_DETECT, 3'd2, 8'h5A);
    drain_results();

    // Random phases with different idling; the first one starts with a
    // long receiver hold while the sender keeps offering transactions.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct <= 0;  stall_pct <= 0;  hold_req <= 1'b1; end
        1: begin gap_pct <= 55; stall_pct <= 0;  end
        2: begin gap_pct <= 0;  stall_pct <= 55; end
        default: begin gap_pct <= 22; stall_pct <= 22; end
      endcase
      @(posedge clk);
      phase_end = cmd_count + ITEMS_PER_PHASE;
      while (cmd_count < phase_end) random_sequence();
      drain_results();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
